### rtl/cbhs_pkg.sv
// Shared constants and types for the clamped bilinear height sampler.
// No dependencies; used by the interfaces and the top level.
package cbhs_pkg;
   localparam int MAX_COLS   = 128;
   localparam int MAX_ROWS   = 128;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int CNT_W      = 8;
   localparam int BANK_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Z   = 3'd1,
      CSR_INV_SPAN_X = 3'd2,
      CSR_INV_SPAN_Z = 3'd3,
      CSR_COLS_USED  = 3'd4,
      CSR_ROWS_USED  = 3'd5
   } csr_index_type;
endpackage

### rtl/cbhs_req_if.sv
// Request channel: cell writes and sample points.
// Depends on cbhs_pkg.
interface cbhs_req_if import cbhs_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                command;
   logic [6:0]          cell_col;
   logic [6:0]          cell_row;
   logic signed [31:0]  cell_height;
   logic signed [31:0]  query_x;
   logic signed [31:0]  query_z;

   modport source (output valid, command, cell_col, cell_row, cell_height, query_x, query_z,
                   input ready);
   modport sink   (input valid, command, cell_col, cell_row, cell_height, query_x, query_z,
                   output ready);
endinterface

### rtl/cbhs_rsp_if.sv
// Response channel: interpolated heights.
// Depends on cbhs_pkg.
interface cbhs_rsp_if import cbhs_pkg::*; ;
   logic                valid;
   logic                ready;
   logic signed [31:0]  height;

   modport source (output valid, height, input ready);
   modport sink   (input valid, height, output ready);
endinterface

### rtl/cbhs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cbhs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

### rtl/clamped_bilinear_height_sampler_unit.sv
// Clamped bilinear height sampler. Takes one transaction per cycle unless stalled, writes and
// samples mixed freely; a sample's height is registered on the way out. The grid sits in four
// banks split by column and row parity, so all four neighbours come out of the same bank read.
// Writes and reads meet the banks at the same stage in order, so a sample sees every
// earlier write. A stall on the response side holds the whole pipeline.
module clamped_bilinear_height_sampler_unit import cbhs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   cbhs_req_if.sink             req_port,
   cbhs_rsp_if.source           rsp_port,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_write_data
);
   logic signed [31:0] origin_x_ff, origin_z_ff;
   logic [31:0]        inv_x_ff, inv_z_ff;
   logic [CNT_W-1:0]   cols_ff, rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_z_ff <= '0;
         inv_x_ff    <= 32'h0100_0000;
         inv_z_ff    <= 32'h0100_0000;
         cols_ff     <= CNT_W'(MAX_COLS);
         rows_ff     <= CNT_W'(MAX_ROWS);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ORIGIN_X:   origin_x_ff <= csr_write_data;
            CSR_ORIGIN_Z:   origin_z_ff <= csr_write_data;
            CSR_INV_SPAN_X: inv_x_ff    <= csr_write_data;
            CSR_INV_SPAN_Z: inv_z_ff    <= csr_write_data;
            CSR_COLS_USED:  cols_ff     <= csr_write_data[CNT_W-1:0];
            CSR_ROWS_USED:  rows_ff     <= csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv            = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = adv;
   assign rsp_port.valid = rsp_valid_ff;

   // valid and command per stage: 0 input, 1 diff, 2 mult, 3 norm, 4 index, 5 read,
   // 6 blend mult, 7 row sum, 8 column mult
   logic [8:0] v_ff, v_in;
   logic [8:0] smp_ff, smp_in;

   // write payload
   logic [COL_W-1:0]   wcol_ff [5];
   logic [ROW_W-1:0]   wrow_ff [5];
   logic signed [31:0] wh_ff   [5];

   logic signed [31:0] qx_ff, qz_ff;
   logic signed [32:0] dx_ff, dz_ff, dx_in, dz_in;
   logic [48:0]        phx_ff, plx_ff, phz_ff, plz_ff;
   logic               posx_ff, posz_ff;
   logic [16:0]        px_ff, pz_ff, px_in, pz_in;
   logic [COL_W-1:0]   c0_ff, c1_ff, c0_in, c1_in;
   logic [ROW_W-1:0]   r0_ff, r1_ff, r0_in, r1_in;
   logic [15:0]        fx_ff [4:5];
   logic [15:0]        fz_ff [4:7];
   logic [15:0]        fx_in, fz_in;
   logic               c0p_ff, c1p_ff, r0p_ff, r1p_ff;
   logic signed [49:0] m00_ff, m10_ff, m01_ff, m11_ff;
   logic signed [31:0] y1_ff, y2_ff, y1_in, y2_in;
   logic signed [49:0] n1_ff, n2_ff;
   logic signed [31:0] out_ff, out_in;

   assign v_in   = {v_ff[7:0], req_port.valid};
   assign smp_in = {smp_ff[7:0], req_port.command == CMD_SAMPLE};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff              <= '0;
         rsp_valid_ff      <= 1'b0;
      end else if (adv) begin
         v_ff              <= v_in;
         rsp_valid_ff      <= v_ff[8] && smp_ff[8];
      end
   end

   // normalise: difference, split multiply, saturate
   assign dx_in = 33'(qx_ff) - 33'(origin_x_ff);
   assign dz_in = 33'(qz_ff) - 33'(origin_z_ff);

   function automatic logic [16:0] norm_q16(input logic pos, input logic [48:0] ph,
                                            input logic [48:0] pl);
      logic [49:0] sum;
      logic [25:0] p;
      sum = {2'b0, ph[23:0], 16'b0} + {1'b0, pl};
      p   = sum[49:24];
      if (!pos)                 norm_q16 = '0;
      else if (ph[48:24] != '0) norm_q16 = ONE_Q16;
      else if (p > 26'(ONE_Q16)) norm_q16 = ONE_Q16;
      else                      norm_q16 = p[16:0];
   endfunction

   assign px_in = norm_q16(posx_ff, phx_ff, plx_ff);
   assign pz_in = norm_q16(posz_ff, phz_ff, plz_ff);

   // scale, split and clamp to the used grid
   logic [CNT_W-1:0] ncol, nrow, ncol_m1, nrow_m1;
   logic [24:0]      sx, sz;
   logic [8:0]       ix, iz, ix1, iz1;

   always_comb begin
      ncol = (cols_ff == '0) ? CNT_W'(1) :
             (cols_ff > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_ff;
      nrow = (rows_ff == '0) ? CNT_W'(1) :
             (rows_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_ff;
      ncol_m1 = ncol - CNT_W'(1);
      nrow_m1 = nrow - CNT_W'(1);
      sx  = px_ff * ncol;
      sz  = pz_ff * nrow;
      ix  = sx[24:16];
      iz  = sz[24:16];
      ix1 = ix + 9'd1;
      iz1 = iz + 9'd1;
      fx_in = sx[15:0];
      fz_in = sz[15:0];
      c0_in = (ix  > 9'(ncol_m1)) ? ncol_m1[COL_W-1:0] : ix[COL_W-1:0];
      c1_in = (ix1 > 9'(ncol_m1)) ? ncol_m1[COL_W-1:0] : ix1[COL_W-1:0];
      r0_in = (iz  > 9'(nrow_m1)) ? nrow_m1[ROW_W-1:0] : iz[ROW_W-1:0];
      r1_in = (iz1 > 9'(nrow_m1)) ? nrow_m1[ROW_W-1:0] : iz1[ROW_W-1:0];
   end

   // banks
   logic [DATA_W-1:0] bank_q [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic             pc, pr, we;
      logic [COL_W-1:0] rc;
      logic [ROW_W-1:0] rr;
      assign pc = 1'((b >> 1) & 1);
      assign pr = 1'(b & 1);
      assign rc = (c0_ff[0] == pc) ? c0_ff : c1_ff;
      assign rr = (r0_ff[0] == pr) ? r0_ff : r1_ff;
      assign we = adv && v_ff[4] && !smp_ff[4] && wcol_ff[4][0] == pc && wrow_ff[4][0] == pr;
      cbhs_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_bank (
         .clock        (clock),
         .write_enable (we),
         .write_addr   ({wcol_ff[4][COL_W-1:1], wrow_ff[4][ROW_W-1:1]}),
         .write_data   (wh_ff[4]),
         .read_enable  (adv),
         .read_addr    ({rc[COL_W-1:1], rr[ROW_W-1:1]}),
         .read_data    (bank_q[b])
      );
   end

   logic signed [31:0] a00, a10, a01, a11;
   assign a00 = bank_q[{c0p_ff, r0p_ff}];
   assign a10 = bank_q[{c1p_ff, r0p_ff}];
   assign a01 = bank_q[{c0p_ff, r1p_ff}];
   assign a11 = bank_q[{c1p_ff, r1p_ff}];

   logic signed [50:0] sum1, sum2, sum3;
   assign sum1  = 51'(m00_ff) + 51'(m10_ff);
   assign sum2  = 51'(m01_ff) + 51'(m11_ff);
   assign sum3  = 51'(n1_ff) + 51'(n2_ff);
   assign y1_in = 32'(sum1 >>> 16);
   assign y2_in = 32'(sum2 >>> 16);
   assign out_in = 32'(sum3 >>> 16);

   function automatic logic signed [17:0] wlo(input logic [15:0] f);
      wlo = $signed({1'b0, ONE_Q16 - {1'b0, f}});
   endfunction

   function automatic logic signed [17:0] whi(input logic [15:0] f);
      whi = $signed({2'b0, f});
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         smp_ff     <= smp_in;
         wcol_ff[0] <= req_port.cell_col;
         wrow_ff[0] <= req_port.cell_row;
         wh_ff[0]   <= req_port.cell_height;
         for (int i = 1; i < 5; i++) begin
            wcol_ff[i] <= wcol_ff[i-1];
            wrow_ff[i] <= wrow_ff[i-1];
            wh_ff[i]   <= wh_ff[i-1];
         end
         qx_ff   <= req_port.query_x;
         qz_ff   <= req_port.query_z;
         dx_ff   <= dx_in;
         dz_ff   <= dz_in;
         posx_ff <= !dx_ff[32] && dx_ff != '0;
         posz_ff <= !dz_ff[32] && dz_ff != '0;
         phx_ff  <= dx_ff[32:0] * inv_x_ff[31:16];
         plx_ff  <= dx_ff[32:0] * inv_x_ff[15:0];
         phz_ff  <= dz_ff[32:0] * inv_z_ff[31:16];
         plz_ff  <= dz_ff[32:0] * inv_z_ff[15:0];
         px_ff   <= px_in;
         pz_ff   <= pz_in;
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         r0_ff   <= r0_in;
         r1_ff   <= r1_in;
         fx_ff[4] <= fx_in;
         fz_ff[4] <= fz_in;
         fx_ff[5] <= fx_ff[4];
         for (int i = 5; i < 8; i++) begin
            fz_ff[i] <= fz_ff[i-1];
         end
         c0p_ff  <= c0_ff[0];
         c1p_ff  <= c1_ff[0];
         r0p_ff  <= r0_ff[0];
         r1p_ff  <= r1_ff[0];
         m00_ff  <= wlo(fx_ff[5]) * a00;
         m10_ff  <= whi(fx_ff[5]) * a10;
         m01_ff  <= wlo(fx_ff[5]) * a01;
         m11_ff  <= whi(fx_ff[5]) * a11;
         y1_ff   <= y1_in;
         y2_ff   <= y2_in;
         n1_ff   <= wlo(fz_ff[7]) * y1_ff;
         n2_ff   <= whi(fz_ff[7]) * y2_ff;
         out_ff  <= out_in;
      end
   end

   assign rsp_port.height = out_ff;
endmodule
